// ===== src/lcdmt_pkg.sv =====
// lcdmt_pkg: shared types and constants of the lcd mode timing block
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package lcdmt_pkg;

    // field widths
    localparam int unsigned CYC_W  = 8;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned CTL_W  = 8;
    localparam int unsigned ENA_W  = 4;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned DATA_W = 8;

    // line timing constants
    localparam logic [LINE_W-1:0] LAST_LINE      = 8'd153;
    localparam int unsigned       OAM_START      = 376;
    localparam int unsigned       TRANSFER_START = 204;

    // lcd_control bits
    localparam int unsigned CTL_BG_EN   = 0;
    localparam int unsigned CTL_SPR_EN  = 1;
    localparam int unsigned CTL_DISP_EN = 7;

    // stat_enables bits
    localparam int unsigned ENA_MODE0 = 0;
    localparam int unsigned ENA_MODE1 = 1;
    localparam int unsigned ENA_MODE2 = 2;
    localparam int unsigned ENA_COIN  = 3;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_LCD_CONTROL  = 2'd0,
        REG_STAT_ENABLES = 2'd1,
        REG_COMPARE_LINE = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    // lcd modes
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } t_mode;

endpackage

// ===== src/lcdmt_if.sv =====
// lcdmt channel interfaces: item input, result output and register write
// depends on lcdmt_pkg for field widths
`timescale 1ns / 1ps

// input channel: one request per elapsed-cycle count
interface lcdmt_in_if;
    logic                          valid;
    logic                          ready;
    logic [lcdmt_pkg::CYC_W-1:0]   elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

// result channel: one status request per input item
interface lcdmt_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    lcd_mode;
    logic [lcdmt_pkg::LINE_W-1:0]  current_line;
    logic                          coincidence;
    logic                          stat_irq;
    logic                          vblank_irq;
    logic                          draw_strobe;
    logic                          draw_background;
    logic                          draw_sprites;
    logic [lcdmt_pkg::LINE_W-1:0]  finished_line;

    modport source (output valid, output lcd_mode, output current_line,
                    output coincidence, output stat_irq, output vblank_irq,
                    output draw_strobe, output draw_background,
                    output draw_sprites, output finished_line, input ready);
    modport sink   (input valid, input lcd_mode, input current_line,
                    input coincidence, input stat_irq, input vblank_irq,
                    input draw_strobe, input draw_background,
                    input draw_sprites, input finished_line, output ready);
endinterface

// register write channel
interface lcdmt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lcdmt_pkg::IDX_W-1:0]   index;
    logic [lcdmt_pkg::DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/lcd_mode_timing.sv =====
// lcd_mode_timing: scanline counter, mode select and interrupt requests
// depends on lcdmt_pkg and the channel interfaces in lcdmt_if.sv
//
// usage: each request on i_in carries the machine cycles elapsed since the
// previous one. for every request the block returns one result on o_res:
// the mode seen before the cycles are applied, the line after the step,
// coincidence, status and vblank interrupt requests and a draw strobe for a
// finished visible line. registers are written on i_cfg (index 0
// lcd_control, 1 stat_enables, 2 compare_line, 3 ignored); i_cfg.ready is
// always high.
// timing: a request is taken into an input register, and the line state and
// result register are updated from it once the result register is empty or
// its result is being taken, so a result passes through the input register
// and then the result register. the counter/line update is one short
// combinational pass, so one request per cycle is sustained while o_res is not stalled.
// stall: while o_res is stalled one more request is held in the input
// register, then i_in.ready drops until the result is taken.
// reset: registers take their reset values, counter LINE_CYCLES, line 0,
// previous mode 0, both pipeline stages empty.
`timescale 1ns / 1ps

module lcd_mode_timing #(
    parameter int unsigned LINE_CYCLES   = 456,
    parameter int unsigned VISIBLE_LINES = 144
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcdmt_in_if.sink     i_in,
    lcdmt_cfg_if.sink    i_cfg,
    lcdmt_out_if.source  o_res
);
    import lcdmt_pkg::*;

    localparam int unsigned CNT_W = $clog2(LINE_CYCLES + 1);
    localparam logic [CNT_W-1:0]  CNT_RELOAD = CNT_W'(LINE_CYCLES);
    localparam logic [CNT_W-1:0]  CNT_OAM    = CNT_W'(OAM_START);
    localparam logic [CNT_W-1:0]  CNT_XFER   = CNT_W'(TRANSFER_START);
    localparam logic [LINE_W-1:0] VIS_LINE   = LINE_W'(VISIBLE_LINES);

    // configuration registers
    logic [CTL_W-1:0]  r_lcd_control;
    logic [ENA_W-1:0]  r_stat_enables;
    logic [LINE_W-1:0] r_compare_line;

    // line state
    logic [CNT_W-1:0]  r_countdown, n_countdown;
    logic [LINE_W-1:0] r_line, n_line;
    t_mode             r_prev_mode, n_prev_mode;

    // input stage
    logic              r_in_valid;
    logic [CYC_W-1:0]  r_cycles;

    // result stage
    logic              r_out_valid;
    t_mode             r_mode, n_mode;
    logic [LINE_W-1:0] r_cur_line;
    logic              r_coin, n_coin;
    logic              r_stat_irq, n_stat_irq;
    logic              r_vblank, n_vblank;
    logic              r_strobe, n_strobe;
    logic              r_bg, n_bg;
    logic              r_spr, n_spr;
    logic [LINE_W-1:0] r_finished, n_finished;

    logic advance;
    logic in_take;
    logic cfg_take;

    assign advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_take  = i_in.valid && i_in.ready;
    assign cfg_take = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // step of the line state for the item in the input register
    always_comb begin
        logic mode_irq_en;
        logic [LINE_W-1:0] next_line;
        mode_irq_en = 1'b0;
        next_line   = '0;
        n_countdown = r_countdown;
        n_line      = r_line;
        n_prev_mode = r_prev_mode;
        n_mode      = MODE_VBLANK;
        n_coin      = 1'b0;
        n_stat_irq  = 1'b0;
        n_vblank    = 1'b0;
        n_strobe    = 1'b0;
        n_bg        = 1'b0;
        n_spr       = 1'b0;
        n_finished  = '0;
        if (!r_lcd_control[CTL_DISP_EN]) begin
            n_countdown = CNT_RELOAD;
            n_line      = '0;
            n_prev_mode = MODE_VBLANK;
        end else begin
            // mode from line and counter
            if (r_line >= VIS_LINE) begin
                n_mode      = MODE_VBLANK;
                mode_irq_en = r_stat_enables[ENA_MODE1];
            end else if (r_countdown >= CNT_OAM) begin
                n_mode      = MODE_OAM;
                mode_irq_en = r_stat_enables[ENA_MODE2];
            end else if (r_countdown >= CNT_XFER) begin
                n_mode      = MODE_TRANSFER;
                mode_irq_en = 1'b0;
            end else begin
                n_mode      = MODE_HBLANK;
                mode_irq_en = r_stat_enables[ENA_MODE0];
            end
            n_stat_irq  = mode_irq_en && (n_mode != r_prev_mode);
            n_prev_mode = n_mode;

            // line compare
            if (r_line == r_compare_line) begin
                n_coin = 1'b1;
                if (r_stat_enables[ENA_COIN]) begin
                    n_stat_irq = 1'b1;
                end
            end

            // counter update and end of line
            if ({{(CNT_W-CYC_W){1'b0}}, r_cycles} >= r_countdown) begin
                next_line   = (r_line >= LAST_LINE) ? '0 : r_line + 1'b1;
                n_countdown = CNT_RELOAD;
                n_line      = next_line;
                n_vblank    = (next_line == VIS_LINE);
                if (r_line < VIS_LINE) begin
                    n_strobe   = 1'b1;
                    n_bg       = r_lcd_control[CTL_BG_EN];
                    n_spr      = r_lcd_control[CTL_SPR_EN];
                    n_finished = r_line;
                end
            end else begin
                n_countdown = r_countdown - {{(CNT_W-CYC_W){1'b0}}, r_cycles};
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcd_control  <= CTL_W'(145);
            r_stat_enables <= '0;
            r_compare_line <= '0;
        end else if (cfg_take) begin
            case (t_reg_idx'(i_cfg.index))
                REG_LCD_CONTROL:  r_lcd_control  <= i_cfg.data;
                REG_STAT_ENABLES: r_stat_enables <= i_cfg.data[ENA_W-1:0];
                REG_COMPARE_LINE: r_compare_line <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // control and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_countdown <= CNT_RELOAD;
            r_line      <= '0;
            r_prev_mode <= MODE_HBLANK;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_countdown <= n_countdown;
                r_line      <= n_line;
                r_prev_mode <= n_prev_mode;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cycles <= i_in.elapsed_cycles;
        end
        if (advance) begin
            r_mode     <= n_mode;
            r_cur_line <= n_line;
            r_coin     <= n_coin;
            r_stat_irq <= n_stat_irq;
            r_vblank   <= n_vblank;
            r_strobe   <= n_strobe;
            r_bg       <= n_bg;
            r_spr      <= n_spr;
            r_finished <= n_finished;
        end
    end

    // result channel
    assign o_res.valid           = r_out_valid;
    assign o_res.lcd_mode        = r_mode;
    assign o_res.current_line    = r_cur_line;
    assign o_res.coincidence     = r_coin;
    assign o_res.stat_irq        = r_stat_irq;
    assign o_res.vblank_irq      = r_vblank;
    assign o_res.draw_strobe     = r_strobe;
    assign o_res.draw_background = r_bg;
    assign o_res.draw_sprites    = r_spr;
    assign o_res.finished_line   = r_finished;

endmodule
